// ----- design/pem_base64_encoder_macros.svh -----
// Assertion macros shared by the PEM base64 encoder modules.
// Expects a clock named clk and a synchronous reset named rst in the user module.
`ifndef PEM_BASE64_ENCODER_MACROS_SVH
`define PEM_BASE64_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

`define PEMB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define PEMB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PEMB_ASSERT(label, prop, msg)

`define PEMB_ASSERT_RST(label, prop, msg)

`endif

`endif

// ----- design/pemb_pkg.sv -----
// Types, constants and character tables of the PEM base64 encoder.
// Used by the front, queue and back modules; depends on nothing.
package pemb_pkg;

  localparam int HEADER_LEN  = 28;
  localparam int FOOTER_LEN  = 26;
  localparam int IDX_W       = 5;
  localparam int COL_W       = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_CW    = 2;

  localparam logic [7:0] PAD_CHAR     = 8'h3d;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0a;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [8*HEADER_LEN-1:0] HEADER_TEXT = "-----BEGIN CERTIFICATE-----\n";
  localparam logic [8*FOOTER_LEN-1:0] FOOTER_TEXT = "-----END CERTIFICATE-----\n";

  typedef struct packed {
    logic            hdr;
    logic            last;
    logic [2:0]      n_text;
    logic [3:0][7:0] text;
  } pemb_cmd_t;

  typedef enum logic [2:0] {
    ST_START,
    ST_HDR,
    ST_TEXT,
    ST_NL,
    ST_END_NL,
    ST_FTR
  } pemb_state_t;

  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    logic [5:0] r;
    r = ~v;
    return ALPHABET[{r, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] header_char(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = IDX_W'(HEADER_LEN - 1) - i;
    return HEADER_TEXT[{r, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] footer_char(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = IDX_W'(FOOTER_LEN - 1) - i;
    return FOOTER_TEXT[{r, 3'b000} +: 8];
  endfunction

endpackage

// ----- design/pemb_front.sv -----
// Front part: accepts DER bytes and turns each into a command of up to four
// encoded characters. Depends on pemb_pkg.
module pemb_front import pemb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      der_valid,
  output logic      der_stall,
  input  logic [7:0] der_byte,
  input  logic      last_byte,
  input  logic      full,
  output logic      push,
  output pemb_cmd_t cmd
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0] group_phase;
  logic [1:0] group_phase_next;
  logic [3:0] leftover_bits;
  logic [3:0] leftover_bits_next;
  logic       in_certificate;
  logic       in_certificate_next;
  logic [1:0] phase_after;
  logic [3:0] left_after;

  assign der_stall = full;
  assign push      = der_valid && !full;

  always_comb begin
    cmd.hdr    = !in_certificate;
    cmd.last   = last_byte;
    cmd.text   = {4{PAD_CHAR}};
    cmd.n_text = 3'd1;
    unique case (group_phase)
      PH_SECOND: begin
        cmd.text[0] = alpha_char({leftover_bits[1:0], der_byte[7:4]});
        left_after  = der_byte[3:0];
        phase_after = PH_THIRD;
      end
      PH_THIRD: begin
        cmd.text[0] = alpha_char({leftover_bits, der_byte[7:6]});
        cmd.text[1] = alpha_char(der_byte[5:0]);
        cmd.n_text  = 3'd2;
        left_after  = 4'd0;
        phase_after = PH_FIRST;
      end
      default: begin
        cmd.text[0] = alpha_char(der_byte[7:2]);
        left_after  = {2'b00, der_byte[1:0]};
        phase_after = PH_SECOND;
      end
    endcase

    group_phase_next    = phase_after;
    leftover_bits_next  = left_after;
    in_certificate_next = 1'b1;
    if (last_byte) begin
      if (phase_after == PH_SECOND) begin
        cmd.text[1] = alpha_char({left_after[1:0], 4'b0000});
        cmd.n_text  = 3'd4;
      end else if (phase_after == PH_THIRD) begin
        cmd.text[1] = alpha_char({left_after, 2'b00});
        cmd.n_text  = 3'd3;
      end
      group_phase_next    = PH_FIRST;
      leftover_bits_next  = 4'd0;
      in_certificate_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase    <= PH_FIRST;
      leftover_bits  <= 4'd0;
      in_certificate <= 1'b0;
    end else if (push) begin
      group_phase    <= group_phase_next;
      leftover_bits  <= leftover_bits_next;
      in_certificate <= in_certificate_next;
    end
  end

endmodule

// ----- design/pemb_fifo.sv -----
// Two-entry command queue between the front and back parts.
// Depends on pemb_pkg and the assertion macros header.
`include "pem_base64_encoder_macros.svh"
module pemb_fifo import pemb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pemb_cmd_t wdata,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output pemb_cmd_t head
);

  pemb_cmd_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;

  assign full       = count == QUEUE_CW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

  `PEMB_ASSERT_RST(a_queue_empty_after_reset, rst |=> (count == '0), "queue not empty after reset")
  `PEMB_ASSERT(a_queue_count_range, count <= QUEUE_CW'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ----- design/pemb_back.sv -----
// Back part: walks each queued command and emits header, encoded text,
// newlines and footer one character per cycle unless the output stalls. Depends on pemb_pkg and macros.
`include "pem_base64_encoder_macros.svh"
module pemb_back import pemb_pkg::*; #(
  parameter int LINE_CHARS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  pemb_cmd_t head,
  output logic      pop,
  output logic      pem_valid,
  input  logic      pem_stall,
  output logic [7:0] out_char,
  output logic      run_last,
  output logic      cert_done
);

  pemb_state_t      state;
  pemb_state_t      state_next;
  pemb_state_t      cur;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] cur_idx;
  logic [COL_W-1:0] column;
  logic [COL_W-1:0] column_next;
  logic [COL_W-1:0] col_inc;
  logic             wrap;
  logic             text_last;
  logic             out_ready;
  logic             active;
  logic [7:0]       emit_char;
  logic             emit_run_last;
  logic             emit_done;
  logic             finish;

  assign out_ready = !pem_valid || !pem_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_START;
      idx    <= '0;
      column <= '0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      column <= column_next;
    end
  end

  always_comb begin
    cur     = state;
    cur_idx = idx;
    if (state == ST_START) begin
      cur     = (head_valid && head.hdr) ? ST_HDR : ST_TEXT;
      cur_idx = '0;
    end
    col_inc   = column + COL_W'(1);
    wrap      = col_inc >= COL_W'(LINE_CHARS);
    text_last = cur_idx[2:0] == (head.n_text - 3'd1);
    active    = (state != ST_START || head_valid) && out_ready;

    state_next    = cur;
    idx_next      = cur_idx;
    column_next   = column;
    emit_char     = NEWLINE_CHAR;
    emit_run_last = 1'b0;
    emit_done     = 1'b0;
    finish        = 1'b0;

    unique case (cur)
      ST_HDR: begin
        emit_char   = header_char(cur_idx);
        column_next = '0;
        if (cur_idx == IDX_W'(HEADER_LEN - 1)) begin
          state_next = ST_TEXT;
          idx_next   = '0;
        end else begin
          idx_next = cur_idx + IDX_W'(1);
        end
      end
      ST_TEXT: begin
        emit_char = head.text[cur_idx[1:0]];
        if (wrap) begin
          column_next = '0;
          state_next  = ST_NL;
        end else begin
          column_next = col_inc;
          if (!text_last) begin
            idx_next = cur_idx + IDX_W'(1);
          end else if (head.last) begin
            state_next = ST_END_NL;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_NL: begin
        column_next = '0;
        if (!text_last) begin
          state_next = ST_TEXT;
          idx_next   = cur_idx + IDX_W'(1);
        end else if (head.last) begin
          state_next = ST_FTR;
          idx_next   = '0;
        end else begin
          finish = 1'b1;
        end
      end
      ST_END_NL: begin
        column_next = '0;
        state_next  = ST_FTR;
        idx_next    = '0;
      end
      ST_FTR: begin
        emit_char   = footer_char(cur_idx);
        column_next = '0;
        if (cur_idx == IDX_W'(FOOTER_LEN - 1)) begin
          emit_done = 1'b1;
          finish    = 1'b1;
        end else begin
          idx_next = cur_idx + IDX_W'(1);
        end
      end
      ST_START: begin
        state_next = ST_START;
      end
    endcase

    if (finish) begin
      emit_run_last = 1'b1;
      state_next    = ST_START;
      idx_next      = '0;
    end
    pop = active && finish;
    if (!active) begin
      state_next  = state;
      idx_next    = idx;
      column_next = column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pem_valid <= 1'b0;
    end else if (out_ready) begin
      pem_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      out_char  <= emit_char;
      run_last  <= emit_run_last;
      cert_done <= emit_done;
    end
  end

  `PEMB_ASSERT(a_column_range, column < COL_W'(LINE_CHARS), "line column reached the line length")
  `PEMB_ASSERT(a_pop_needs_head, pop |-> head_valid, "command popped from an empty queue")
  `PEMB_ASSERT(a_footer_resets, (pop && emit_done) |=> (state == ST_START && column == '0), "state not cleared after footer")

endmodule

// ----- design/pem_base64_encoder.sv -----
// Top level of the PEM base64 encoder: front part, command queue and back part.
// Depends on pemb_pkg, pemb_front, pemb_fifo and pemb_back.
//
// Usage: DER bytes enter one per item on der_valid/der_stall with der_byte and
// last_byte; last_byte marks the final byte of a certificate. PEM text leaves
// one character per item on pem_valid/pem_stall as out_char, with run_last on
// the final character caused by an input byte and cert_done on the newline
// that ends the footer. The first byte of a certificate brings the BEGIN line,
// the final byte brings any padding, a closing newline and the END line.
// With the back part idle, an accepted byte is written into the queue and its first
// character is then registered into the output register. The back part emits one
// character per cycle while it has commands and the receiver does not stall. Each
// byte causes one or two encoded characters plus a newline at each line break; the
// first byte adds the 28 header characters, the final byte up to two pad characters.
// A two-entry command queue lets bytes be taken while the back part works; the
// pace of body bytes is set by the single output port.
// Reset empties the queue and the output register and prepares the header.
// While the receiver stalls, the offered character holds and the queue fills,
// after which der_stall stays high until the back part finishes a command.
module pem_base64_encoder import pemb_pkg::*; #(
  parameter int LINE_CHARS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       der_valid,
  output logic       der_stall,
  input  logic [7:0] der_byte,
  input  logic       last_byte,
  output logic       pem_valid,
  input  logic       pem_stall,
  output logic [7:0] out_char,
  output logic       run_last,
  output logic       cert_done
);

  pemb_cmd_t front_cmd;
  pemb_cmd_t head;
  logic      push;
  logic      pop;
  logic      full;
  logic      head_valid;

  pemb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .der_valid (der_valid),
    .der_stall (der_stall),
    .der_byte  (der_byte),
    .last_byte (last_byte),
    .full      (full),
    .push      (push),
    .cmd       (front_cmd)
  );

  pemb_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wdata      (front_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  pemb_back #(
    .LINE_CHARS (LINE_CHARS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .pem_valid  (pem_valid),
    .pem_stall  (pem_stall),
    .out_char   (out_char),
    .run_last   (run_last),
    .cert_done  (cert_done)
  );

endmodule
